FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/sfp_pkg.sv
package sfp_pkg;

  // field widths
  localparam int SAMPLE_W      = 16;
  localparam int RESULT_W      = 15;
  localparam int MAG_W         = SAMPLE_W + 1;

  // fixed-point format and correction table geometry
  localparam int FRAC_BITS     = 8;
  localparam int SEGMENT_COUNT = 64;
  localparam int SEG_W         = $clog2(SEGMENT_COUNT);
  localparam int RANGE_LSB     = 8 << FRAC_BITS;
  localparam int OFS_W         = $clog2(RANGE_LSB / SEGMENT_COUNT);
  localparam int ROM_W         = 8;
  localparam int ROM_IDX_W     = SEG_W + 1;
  localparam int ACC_W         = ROM_W + OFS_W + 1;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH   = 4;

  // classified sample handed from front to back
  typedef struct packed {
    logic                in_range;
    logic [RESULT_W-1:0] pos;
    logic [SEG_W-1:0]    seg;
    logic [OFS_W-1:0]    ofs;
  } sfp_item_t;

  // ln(1 + exp(-t)) at t = 8k/64, rounded to 8 fraction bits
  localparam logic [ROM_W-1:0] CORR_ROM [SEGMENT_COUNT+1] = '{
    8'd177, 8'd162, 8'd147, 8'd134, 8'd121, 8'd110, 8'd99,  8'd89,
    8'd80,  8'd72,  8'd64,  8'd58,  8'd52,  8'd46,  8'd41,  8'd37,
    8'd32,  8'd29,  8'd26,  8'd23,  8'd20,  8'd18,  8'd16,  8'd14,
    8'd12,  8'd11,  8'd10,  8'd9,   8'd8,   8'd7,   8'd6,   8'd5,
    8'd5,   8'd4,   8'd4,   8'd3,   8'd3,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0
  };

endpackage

FILE: hw/rtl/sfp_front.sv
module sfp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [sfp_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                item_valid,
  output sfp_pkg::sfp_item_t                  item,
  input  logic                                item_stall
);
  import sfp_pkg::*;

  logic [MAG_W-1:0] mag;
  sfp_item_t        item_next;

  // magnitude without overflow on the most negative sample, then classify
  always_comb begin
    if (sample_in[SAMPLE_W-1]) begin
      mag = MAG_W'(0) - {sample_in[SAMPLE_W-1], sample_in};
    end else begin
      mag = {1'b0, sample_in};
    end
    item_next.in_range = (mag < MAG_W'(RANGE_LSB));
    item_next.pos      = sample_in[SAMPLE_W-1] ? '0 : sample_in[RESULT_W-1:0];
    item_next.seg      = mag[OFS_W +: SEG_W];
    item_next.ofs      = mag[OFS_W-1:0];
  end

  // hold the input side only while the stage is full and blocked
  assign sample_stall = item_valid && item_stall;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!sample_stall) begin
      item_valid <= sample_valid;
    end
    if (sample_valid && !sample_stall) begin
      item <= item_next;
    end
  end

endmodule

FILE: hw/rtl/sfp_queue.sv
module sfp_queue #(
  parameter int DEPTH = sfp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_stall,
  input  sfp_pkg::sfp_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_stall,
  output sfp_pkg::sfp_item_t pop_item
);
  import sfp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfp_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  // handshake on both sides
  assign push_stall = (count == CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_item   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/sfp_back.sv
module sfp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  sfp_pkg::sfp_item_t           item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [sfp_pkg::RESULT_W-1:0] result,
  output logic                         saturated
);
  import sfp_pkg::*;

  logic [ROM_IDX_W-1:0] idx_lo;
  logic [ROM_IDX_W-1:0] idx_hi;
  logic [OFS_W:0]       w_lo;
  logic [OFS_W:0]       w_hi;
  logic [ACC_W-1:0]     acc;
  logic [ROM_W-1:0]     term;
  logic [RESULT_W:0]    sum;
  logic                 take;

  // interpolate between neighbouring table entries, rounding half up
  always_comb begin
    idx_lo = {1'b0, item.seg};
    idx_hi = idx_lo + 1'b1;
    w_hi   = {1'b0, item.ofs};
    w_lo   = (OFS_W + 1)'(1 << OFS_W) - w_hi;
    acc    = ACC_W'(CORR_ROM[idx_lo]) * ACC_W'(w_lo)
           + ACC_W'(CORR_ROM[idx_hi]) * ACC_W'(w_hi)
           + ACC_W'(1 << (OFS_W - 1));
    term   = item.in_range ? acc[OFS_W +: ROM_W] : '0;
    sum    = {1'b0, item.pos} + (RESULT_W + 1)'(term);
  end

  // output register frees up whenever its transaction is taken
  assign item_stall = result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!item_stall) begin
      result_valid <= item_valid;
    end
    if (take) begin
      saturated <= sum[RESULT_W];
      result    <= sum[RESULT_W] ? '1 : sum[RESULT_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/softplus_activation_top.sv
// Softplus activation, y = max(x,0) + ln(1 + exp(-|x|)), on signed Q8.8
// samples, giving an unsigned Q7.8 result in 15 bits that clips at 32767 and
// raises saturated when it does. The correction term is interpolated linearly
// from a 65-entry constant table over |x| in [0,8) and is zero beyond. One
// transaction is taken every cycle while the queue has room; a result passes
// three registers (front register loaded at the edge that accepts its sample,
// queue slot, output register), and a queue of four entries by default
// between the classifying front and the interpolating back absorbs stalls on
// the result side.
module softplus_activation_top #(
  parameter int QUEUE_DEPTH = sfp_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [sfp_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [sfp_pkg::RESULT_W-1:0]        result,
  output logic                                saturated
);
  import sfp_pkg::*;

  logic      front_valid;
  logic      front_stall;
  sfp_item_t front_item;
  logic      back_valid;
  logic      back_stall;
  sfp_item_t back_item;

  // classify samples
  sfp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_in    (sample_in),
    .item_valid   (front_valid),
    .item         (front_item),
    .item_stall   (front_stall)
  );

  // decoupling queue
  sfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_stall  (back_stall),
    .pop_item   (back_item)
  );

  // interpolate, add and saturate
  sfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (back_valid),
    .item_stall   (back_stall),
    .item         (back_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .saturated    (saturated)
  );

endmodule

FILE: hw/rtl/sfp_checker.sv
`include "assert_macros.svh"

module sfp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_stall,
  input logic signed [sfp_pkg::SAMPLE_W-1:0] sample_in,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic [sfp_pkg::RESULT_W-1:0]        result,
  input logic                                saturated
);

  // a stalled result transaction holds
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result) && $stable(saturated))

  // a clipped result is always the maximum code
  `ASSERT_IMPL(a_sat_max, clk, rst, result_valid && saturated, (&result))

  // a result side that is unstalled now and as last sampled leaves room in the queue
  `ASSERT_IMPL(a_no_backpressure, clk, rst, !result_stall && $past(!result_stall), !sample_stall)

endmodule

bind softplus_activation_top sfp_checker u_sfp_checker (.*);

FILE: sim/softplus_activation_top_test.sv
module softplus_activation_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfp_pkg::*;

  localparam int SAMPLE_COUNT = 1650;
  localparam int CALM_TAIL    = 150;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int RESULT_MAX   = (1 << RESULT_W) - 1;

  // one softplus result as the block should present it
  typedef struct {
    logic [RESULT_W-1:0] value;
    logic                clipped;
  } softplus_out_t;

  // predicts softplus per accepted sample and checks results in order
  class softplus_scoreboard;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam int              TERMS   = 24;

    int unsigned     corr_table [SEGMENT_COUNT+1];
    softplus_out_t   awaited [$];
    int              errors;

    // e^-f in Q30, f in [0, 1] given in Q30, as reciprocal of a taylor series
    function longint unsigned exp_neg_q30(longint unsigned f);
      longint unsigned term;
      longint unsigned sum;
      term = ONE_Q30;
      sum  = ONE_Q30;
      for (int i = 1; i <= TERMS; i++) begin
        term = ((term * f) >> 30) / i;
        sum += term;
      end
      return (64'd1 << 60) / sum;
    endfunction

    // correction table: ln(1 + e^-t) at t = 8k/SEGMENT_COUNT, rounded half up
    function new();
      longint unsigned einv;
      longint unsigned num;
      longint unsigned whole;
      longint unsigned frac;
      longint unsigned z;
      longint unsigned u;
      longint unsigned u2;
      longint unsigned pw;
      longint unsigned acc;
      errors = 0;
      einv   = exp_neg_q30(ONE_Q30);
      for (int k = 0; k <= SEGMENT_COUNT; k++) begin
        num   = 64'(8 * k);
        whole = num / SEGMENT_COUNT;
        frac  = ((num % SEGMENT_COUNT) << 30) / SEGMENT_COUNT;
        z     = exp_neg_q30(frac);
        for (longint unsigned j = 0; j < whole; j++)
          z = (z * einv) >> 30;
        // ln(1 + z) = 2 atanh(z / (2 + z))
        u   = (z << 30) / (2 * ONE_Q30 + z);
        u2  = (u * u) >> 30;
        pw  = u;
        acc = 0;
        for (int i = 0; i < TERMS; i++) begin
          acc += pw / (2 * i + 1);
          pw   = (pw * u2) >> 30;
        end
        acc            = 2 * acc;
        corr_table[k]  = 32'((acc + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
      end
    endfunction

    // work out the softplus of an accepted sample and queue it
    function void take_sample(logic [SAMPLE_W-1:0] raw);
      longint unsigned mag;
      longint unsigned pos;
      longint unsigned p;
      longint unsigned seg;
      longint unsigned rem;
      longint unsigned blend;
      longint unsigned corr;
      longint unsigned sum;
      softplus_out_t   want;
      if (raw[SAMPLE_W-1]) begin
        mag = (64'd1 << SAMPLE_W) - 64'(raw);
        pos = 0;
      end else begin
        mag = 64'(raw);
        pos = 64'(raw);
      end
      corr = 0;
      // linear interpolation between table endpoints below |x| = 8
      if (mag < RANGE_LSB) begin
        p     = mag * SEGMENT_COUNT;
        seg   = p / RANGE_LSB;
        rem   = p % RANGE_LSB;
        blend = corr_table[seg] * (RANGE_LSB - rem) + corr_table[seg+1] * rem;
        corr  = (blend + RANGE_LSB / 2) / RANGE_LSB;
      end
      sum          = pos + corr;
      want.clipped = (sum > RESULT_MAX);
      want.value   = want.clipped ? RESULT_W'(RESULT_MAX) : RESULT_W'(sum);
      awaited.push_back(want);
    endfunction

    // compare one accepted result with the oldest prediction
    function void compare_result(logic [RESULT_W-1:0] value, logic clipped);
      softplus_out_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result %0d saturated %0b with none expected", $time,
                 value, clipped);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value) begin
        $display("%0t: result expected %0d actual %0d", $time, want.value, value);
        errors++;
      end
      if (clipped !== want.clipped) begin
        $display("%0t: saturated expected %0b actual %0b", $time, want.clipped,
                 clipped);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       sample_valid;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       result_valid;
  logic                       result_stall;
  logic [RESULT_W-1:0]        result;
  logic                       saturated;

  // no idling on either side near the end of the run
  bit calm;

  softplus_scoreboard softplus_sb;

  softplus_activation_top DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .saturated    (saturated)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hand one sample over and note it once the transaction completes
  task automatic send_sample(logic [SAMPLE_W-1:0] x);
    sample_in    <= x;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall)
      @(posedge clk);
    softplus_sb.take_sample(x);
  endtask

  // random gap in the sample stream, skipped in quiet stretches
  task automatic sample_gap(int idx);
    if (!calm && (idx % 200) >= 40 && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 16))
        @(posedge clk);
    end
  endtask

  // corner samples: zero, range ends, table range edges, segment edges, bit patterns
  logic [SAMPLE_W-1:0] corner_samples [$] = '{
    16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
    16'h07FF, 16'h0800, 16'h0801, 16'hF801, 16'hF800,
    16'hF7FF, 16'h0020, 16'h001F, 16'h0021, 16'hFFE0,
    16'h0400, 16'hFC00, 16'h0080, 16'hFF80, 16'h5555,
    16'hAAAA, 16'h0010, 16'h07E0, 16'h4000, 16'hC000
  };

  // stimulus and end of run
  initial begin
    int          mag;
    int          guard;
    logic [SAMPLE_W-1:0] x;
    softplus_sb  = new();
    calm         = 1'b0;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample_in    <= '0;
    repeat (5)
      @(posedge clk);
    rst <= 1'b0;

    foreach (corner_samples[i]) begin
      sample_gap(i + 40);
      send_sample(corner_samples[i]);
    end

    for (int i = 0; i < SAMPLE_COUNT - corner_samples.size(); i++) begin
      if (i >= SAMPLE_COUNT - corner_samples.size() - CALM_TAIL)
        calm = 1'b1;
      sample_gap(i);
      case ($urandom_range(0, 9))
        6, 7:    mag = $urandom_range(0, 65535);
        8:       mag = $urandom_range(RANGE_LSB - 8, RANGE_LSB + 8);
        9:       mag = (RANGE_LSB / SEGMENT_COUNT) * $urandom_range(0, SEGMENT_COUNT)
                       + $urandom_range(0, 2) - 1;
        default: mag = $urandom_range(0, RANGE_LSB - 1);
      endcase
      x = SAMPLE_W'(mag);
      // random sign for any magnitude below 32768
      if (mag < 32768 && $urandom_range(0, 1) == 1)
        x = SAMPLE_W'(-mag);
      send_sample(x);
    end
    sample_valid <= 1'b0;

    // drain, then wait on so that any unexpected result is still seen
    guard = 0;
    while (softplus_sb.outstanding() > 0 && guard < DRAIN_LIMIT) begin
      guard++;
      @(posedge clk);
    end
    repeat (8)
      @(posedge clk);
    if (softplus_sb.outstanding() > 0) begin
      $display("%0t: %0d results expected but never seen", $time,
               softplus_sb.outstanding());
      softplus_sb.errors++;
    end

    if (softplus_sb.errors == 0)
      $display("softplus_activation_top: match");
    else
      $display("softplus_activation_top: mismatch");
    $finish;
  end

  // result side back-pressure in random bursts
  initial begin
    int n;
    forever begin
      if (calm) begin
        result_stall <= 1'b0;
        @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            result_stall <= 1'b1;
            n = $urandom_range(1, 16);
          end
          1: begin
            result_stall <= 1'b0;
            n = $urandom_range(20, 80);
          end
          default: begin
            result_stall <= 1'b0;
            n = $urandom_range(1, 16);
          end
        endcase
        repeat (n)
          @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      softplus_sb.compare_result(result, saturated);
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("softplus_activation_top: mismatch");
    $finish;
  end

endmodule
